FILE: rtl/adcdb_pkg.sv
// shared types and constants for the adc channel deadband scaler
// used by adcdb_scale and adc_channel_deadband_scaler_unit, no dependencies
`default_nettype none

package adcdb_pkg;

  localparam int CHANNELS   = 6;
  localparam int SAMPLE_MAX = 1023;
  localparam int VAR_COUNT  = 64;

  localparam int CH_W       = 3;
  localparam int SAMPLE_W   = 10;
  localparam int THRESH_W   = 10;
  localparam int VALUE_W    = 16;
  localparam int VAR_W      = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int MAP_W      = 49;
  localparam int S_TDATA_W  = 16;
  localparam int M_TDATA_W  = 40;

  // sample * |out_b - out_a|
  localparam int MAG_W      = SAMPLE_W + VALUE_W;

  // x / SAMPLE_MAX == (x * RECIP_MUL) >> RECIP_SHIFT, exact for x below 2**30
  localparam int      RECIP_SHIFT = 40;
  localparam longint  RECIP_FULL  = ((64'd1 << RECIP_SHIFT) + SAMPLE_MAX - 1) / SAMPLE_MAX;
  localparam int      RECIP_W     = $clog2(RECIP_FULL + 1);
  localparam int      PROD_W      = MAG_W + RECIP_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLE = 3'd0,
    CFG_THRESH = 3'd1,
    CFG_MAP0   = 3'd2,
    CFG_MAP1   = 3'd3,
    CFG_MAP2   = 3'd4,
    CFG_MAP3   = 3'd5,
    CFG_MAP4   = 3'd6,
    CFG_MAP5   = 3'd7
  } cfg_reg_t;

  typedef enum logic {
    KIND_RAW   = 1'b0,
    KIND_WRITE = 1'b1
  } kind_t;

  // layout of one map register, lowest field last
  typedef struct packed {
    logic                mapped;
    logic [VAR_W-1:0]    var_idx;
    logic [VAR_W-1:0]    var_id;
    logic [VALUE_W-1:0]  out_b;
    logic [VALUE_W-1:0]  out_a;
  } map_word_t;

  // what the pipeline carries of the map word
  typedef struct packed {
    logic                write_ok;
    logic [VAR_W-1:0]    var_idx;
    logic [VAR_W-1:0]    var_id;
    logic [VALUE_W-1:0]  out_a;
  } map_info_t;

endpackage

`default_nettype wire

FILE: rtl/adcdb_scale.sv
// registered divide by SAMPLE_MAX through a reciprocal multiply
// depends on adcdb_pkg
`default_nettype none

module adcdb_scale (
  input  wire logic                          clk,
  input  wire logic                          en,
  input  wire logic [adcdb_pkg::MAG_W-1:0]   mag,
  output logic      [adcdb_pkg::VALUE_W-1:0] quot
);

  localparam logic [adcdb_pkg::RECIP_W-1:0] RecipMul =
    adcdb_pkg::RECIP_W'(adcdb_pkg::RECIP_FULL);

  logic [adcdb_pkg::PROD_W-1:0] prod;

  assign prod = adcdb_pkg::PROD_W'(mag) * adcdb_pkg::PROD_W'(RecipMul);

  always_ff @(posedge clk) begin
    if (en) begin
      quot <= prod[adcdb_pkg::RECIP_SHIFT +: adcdb_pkg::VALUE_W];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/adc_channel_deadband_scaler_unit.sv
// path: a changed sample passes the input, decision, divide and output registers to its raw
// report, the write next; throughput: one sample per cycle in while s_tready is high; output
// carries one or two results per kept sample and holds each sample until its last is taken
// reset: synchronous active high rst clears config, stored channel values and all valids
// depends on adcdb_pkg and adcdb_scale
`default_nettype none

module adc_channel_deadband_scaler_unit (
  input  wire logic                               clk,
  input  wire logic                               rst,
  // s_tdata: channel [2:0], sample [12:3], zero fill
  input  wire logic                               s_tvalid,
  output logic                                    s_tready,
  input  wire logic [adcdb_pkg::S_TDATA_W-1:0]    s_tdata,
  // m_tdata: chan_out [2:0], target_var [10:3], target_index [18:11], value [34:19], zero fill
  // m_tuser: kind
  output logic                                    m_tvalid,
  input  wire logic                               m_tready,
  output logic      [adcdb_pkg::M_TDATA_W-1:0]    m_tdata,
  output logic                                    m_tuser,
  output logic                                    m_tlast,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [adcdb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [adcdb_pkg::MAP_W-1:0]        cfg_data
);

  localparam int ChW  = adcdb_pkg::CH_W;
  localparam int SmpW = adcdb_pkg::SAMPLE_W;
  localparam int ValW = adcdb_pkg::VALUE_W;

  // configuration
  logic [adcdb_pkg::CHANNELS-1:0]   enable_mask;
  logic [adcdb_pkg::THRESH_W-1:0]   thresh;
  adcdb_pkg::map_word_t             map_word [adcdb_pkg::CHANNELS];
  logic [ChW-1:0]                   map_sel;

  logic [adcdb_pkg::CHANNELS-1:0][SmpW-1:0] reported_value;

  // input stage
  logic            s0_valid;
  logic [ChW-1:0]  s0_ch;
  logic [SmpW-1:0] s0_sample;

  // decision and first multiply stage
  logic                  s1_valid;
  logic [ChW-1:0]        s1_ch;
  logic [SmpW-1:0]       s1_sample;
  adcdb_pkg::map_info_t  s1_info;
  logic                  s1_neg;
  logic [adcdb_pkg::MAG_W-1:0] s1_mag;

  // divide stage
  logic                  s2_valid;
  logic [ChW-1:0]        s2_ch;
  logic [SmpW-1:0]       s2_sample;
  adcdb_pkg::map_info_t  s2_info;
  logic                  s2_neg;
  logic [ValW-1:0]       s2_quot;

  // output stage
  logic                  o_valid;
  logic                  o_phase;
  logic [ChW-1:0]        o_ch;
  logic [SmpW-1:0]       o_sample;
  adcdb_pkg::map_info_t  o_info;
  logic [ValW-1:0]       o_value;

  logic o_free, s2_ready, s1_ready, s0_ready, s0_adv;

  // decision signals
  logic                  ch_ok;
  logic [ChW-1:0]        ch_idx;
  logic [SmpW-1:0]       old_val;
  logic [SmpW-1:0]       smp_diff;
  logic                  keep;
  adcdb_pkg::map_word_t  cur_map;
  logic signed [ValW:0]  span;
  logic [ValW-1:0]       span_mag;
  adcdb_pkg::map_info_t  cur_info;

  logic [ValW-1:0]       mapped_value;

  // ---------------------------------------------------------------- config port
  assign cfg_ready = 1'b1;
  assign map_sel   = cfg_index - adcdb_pkg::CFG_MAP0;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable_mask <= '0;
      thresh      <= '0;
      for (int i = 0; i < adcdb_pkg::CHANNELS; i++) begin
        map_word[i] <= '0;
      end
    end else if (cfg_valid) begin
      case (adcdb_pkg::cfg_reg_t'(cfg_index))
        adcdb_pkg::CFG_ENABLE: enable_mask <= cfg_data[adcdb_pkg::CHANNELS-1:0];
        adcdb_pkg::CFG_THRESH: thresh      <= cfg_data[adcdb_pkg::THRESH_W-1:0];
        default: begin
          map_word[map_sel] <= adcdb_pkg::map_word_t'(cfg_data);
        end
      endcase
    end
  end

  // ---------------------------------------------------------------- flow control
  assign o_free   = !o_valid || (m_tready && m_tlast);
  assign s2_ready = !s2_valid || o_free;
  assign s1_ready = !s1_valid || s2_ready;
  assign s0_ready = !s0_valid || s1_ready;
  assign s0_adv   = s0_valid && s1_ready;
  assign s_tready = s0_ready;

  // ---------------------------------------------------------------- input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (s0_ready) begin
      s0_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s0_ready) begin
      s0_ch     <= s_tdata[ChW-1:0];
      s0_sample <= s_tdata[ChW +: SmpW];
    end
  end

  // ---------------------------------------------------------------- decision
  assign ch_ok    = s0_ch < ChW'(adcdb_pkg::CHANNELS);
  assign ch_idx   = ch_ok ? s0_ch : '0;
  assign old_val  = reported_value[ch_idx];
  assign smp_diff = (s0_sample > old_val) ? (s0_sample - old_val) : (old_val - s0_sample);
  assign keep     = ch_ok && enable_mask[ch_idx] && (s0_sample != old_val)
                    && !((thresh != '0) && (smp_diff < thresh));

  assign cur_map  = map_word[ch_idx];
  assign span     = $signed({1'b0, cur_map.out_b}) - $signed({1'b0, cur_map.out_a});
  assign span_mag = span[ValW] ? ValW'(-span) : span[ValW-1:0];

  always_comb begin
    cur_info          = '0;
    cur_info.write_ok = cur_map.mapped && (cur_map.var_id < adcdb_pkg::VAR_W'(adcdb_pkg::VAR_COUNT));
    cur_info.var_id   = cur_map.var_id;
    cur_info.var_idx  = cur_map.var_idx;
    cur_info.out_a    = cur_map.out_a;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reported_value <= '0;
    end else if (s0_adv && keep) begin
      reported_value[ch_idx] <= s0_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= s0_valid && keep;
    end
  end

  always_ff @(posedge clk) begin
    if (s0_adv) begin
      s1_ch     <= s0_ch;
      s1_sample <= s0_sample;
      s1_info   <= cur_info;
      s1_neg    <= span[ValW];
      s1_mag    <= adcdb_pkg::MAG_W'(s0_sample) * adcdb_pkg::MAG_W'(span_mag);
    end
  end

  // ---------------------------------------------------------------- divide stage
  adcdb_scale u_scale (
    .clk  (clk),
    .en   (s1_valid && s2_ready),
    .mag  (s1_mag),
    .quot (s2_quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_ready) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s2_ready) begin
      s2_ch     <= s1_ch;
      s2_sample <= s1_sample;
      s2_info   <= s1_info;
      s2_neg    <= s1_neg;
    end
  end

  // truncation toward zero: divide the magnitude, then apply the sign
  assign mapped_value = s2_neg ? (s2_info.out_a - s2_quot) : (s2_info.out_a + s2_quot);

  // ---------------------------------------------------------------- output stage
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
      o_phase <= 1'b0;
    end else if (o_free) begin
      o_valid <= s2_valid;
      o_phase <= 1'b0;
    end else if (m_tready) begin
      // raw report taken, the variable write follows
      o_phase <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_valid && o_free) begin
      o_ch     <= s2_ch;
      o_sample <= s2_sample;
      o_info   <= s2_info;
      o_value  <= mapped_value;
    end
  end

  assign m_tvalid = o_valid;
  assign m_tuser  = o_phase ? adcdb_pkg::KIND_WRITE : adcdb_pkg::KIND_RAW;
  assign m_tlast  = o_phase || !o_info.write_ok;
  assign m_tdata  = {
    (adcdb_pkg::M_TDATA_W - ChW - 2*adcdb_pkg::VAR_W - ValW)'(0),
    o_phase ? o_value : ValW'(o_sample),
    o_phase ? o_info.var_idx : adcdb_pkg::VAR_W'(0),
    o_phase ? o_info.var_id  : adcdb_pkg::VAR_W'(0),
    o_ch
  };

  // ---------------------------------------------------------------- assertions
  a_write_is_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> m_tlast)
    else $error("variable write not marked last");

  a_write_follows_raw: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && !m_tlast) |=> (m_tvalid && m_tuser))
    else $error("raw report without its variable write");

  a_kept_channel_valid: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> (s1_ch < ChW'(adcdb_pkg::CHANNELS)))
    else $error("out of range channel entered pipeline");

  a_state_only_on_keep: assert property (@(posedge clk) disable iff (rst)
    !(s0_adv && keep) |=> $stable(reported_value))
    else $error("stored channel value changed without a kept transaction");

  a_kept_sample_stored: assert property (@(posedge clk) disable iff (rst)
    (s0_adv && keep) |=> (reported_value[$past(ch_idx)] == $past(s0_sample)))
    else $error("kept sample not stored");

endmodule

`default_nettype wire

FILE: tb/tb_adc_channel_deadband_scaler_unit.sv
// self-checking testbench for adc_channel_deadband_scaler_unit: directed table, then random phases
// predicts deadband suppression and map scaling per accepted sample, checks every output transaction
// depends on adcdb_pkg and the rtl of the unit
`default_nettype none

module tb_adc_channel_deadband_scaler_unit;

  localparam int NUM_CH          = adcdb_pkg::CHANNELS;
  localparam int FULL_SCALE      = adcdb_pkg::SAMPLE_MAX;
  localparam int VAR_LIMIT       = adcdb_pkg::VAR_COUNT;
  localparam int SETTLE_CYCLES   = 12;
  localparam int STALL_LIMIT     = 3000;
  localparam int HOLD_OFF_CYCLES = 200;
  localparam int PREDICT         = -1;
  localparam int PLAN_ROWS       = 36;
  localparam int PHASES          = 11;

  typedef struct packed {
    adcdb_pkg::kind_t kind;
    logic [2:0]       chan;
    logic [7:0]       tgt_var;
    logic [7:0]       tgt_idx;
    logic [15:0]      value;
    logic             last;
  } adc_result_t;

  typedef enum logic {ROW_CFG, ROW_SMP} row_op_t;

  // sel is a register for config rows, a channel for sample rows
  typedef struct {
    row_op_t     op;
    logic [2:0]  sel;
    logic [48:0] data;
    int          n_exp;
    logic [7:0]  w_var;
    logic [7:0]  w_idx;
    logic [15:0] w_val;
  } plan_row_t;

  logic                            clk       = 1'b0;
  logic                            rst       = 1'b1;
  logic                            s_tvalid  = 1'b0;
  logic                            s_tready;
  logic [adcdb_pkg::S_TDATA_W-1:0] s_tdata   = '0;
  logic                            m_tvalid;
  logic                            m_tready  = 1'b0;
  logic [adcdb_pkg::M_TDATA_W-1:0] m_tdata;
  logic                            m_tuser;
  logic                            m_tlast;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [adcdb_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [adcdb_pkg::MAP_W-1:0]     cfg_data  = '0;

  // predictor copy of configuration and channel state
  logic [5:0]            enable_mask;
  logic [9:0]            deadband;
  adcdb_pkg::map_word_t  chan_map [NUM_CH];
  logic [9:0]            last_reported [NUM_CH];

  adc_result_t reports_due [$];
  int          errors       = 0;
  int          idle_cycles  = 0;
  bit          burst_mode   = 1'b0;
  bit          hold_off_req = 1'b0;

  plan_row_t dir_plan [PLAN_ROWS] = '{
    '{ROW_SMP, 3'd0, 49'd5, 0, 8'd0, 8'd0, 16'd0},
    '{ROW_CFG, adcdb_pkg::CFG_ENABLE, 49'h3F, 0, 8'd0, 8'd0, 16'd0},
    '{ROW_SMP, 3'd0, 49'd0, 0, 8'd0, 8'd0, 16'd0},
    '{ROW_SMP, 3'd0, 49'd1023, 1, 8'd0, 8'd0, 16'd0},
    '{ROW_SMP, 3'd1, 49'd1, 1, 8'd0, 8'd0, 16'd0},
    '{ROW_SMP, 3'd6, 49'd100, 0, 8'd0, 8'd0, 16'd0},
    '{ROW_SMP, 3'd7, 49'd1023, 0, 8'd0, 8'd0, 16'd0},
    '{ROW_SMP, 3'd1, 49'd1, 0, 8'd0, 8'd0, 16'd0},
    '{ROW_CFG, adcdb_pkg::CFG_THRESH, 49'd10, 0, 8'd0, 8'd0, 16'd0},
    '{ROW_SMP, 3'd1, 49'd10, 0, 8'd0, 8'd0, 16'd0},
    '{ROW_SMP, 3'd1, 49'd11, 1, 8'd0, 8'd0, 16'd0},
    '{ROW_SMP, 3'd1, 49'd1, 1, 8'd0, 8'd0, 16'd0},
    '{ROW_CFG, adcdb_pkg::CFG_THRESH, 49'd1023, 0, 8'd0, 8'd0, 16'd0},
    '{ROW_SMP, 3'd0, 49'd1, 0, 8'd0, 8'd0, 16'd0},
    '{ROW_SMP, 3'd0, 49'd0, 1, 8'd0, 8'd0, 16'd0},
    '{ROW_CFG, adcdb_pkg::CFG_THRESH, 49'd0, 0, 8'd0, 8'd0, 16'd0},
    '{ROW_CFG, adcdb_pkg::CFG_MAP0, {1'b1, 8'hFF, 8'd63, 16'hFFFF, 16'h0000}, 0,
      8'd0, 8'd0, 16'd0},
    '{ROW_SMP, 3'd0, 49'd1023, 2, 8'd63, 8'hFF, 16'hFFFF},
    '{ROW_SMP, 3'd0, 49'd0, 2, 8'd63, 8'hFF, 16'h0000},
    '{ROW_CFG, adcdb_pkg::CFG_MAP1, {1'b1, 8'd3, 8'd64, 16'd500, 16'd100}, 0,
      8'd0, 8'd0, 16'd0},
    '{ROW_SMP, 3'd1, 49'd500, 1, 8'd0, 8'd0, 16'd0},
    '{ROW_CFG, adcdb_pkg::CFG_MAP2, {1'b1, 8'd0, 8'd0, 16'd0, 16'd1000}, 0,
      8'd0, 8'd0, 16'd0},
    '{ROW_SMP, 3'd2, 49'd1023, 2, 8'd0, 8'd0, 16'd0},
    '{ROW_SMP, 3'd2, 49'd1, 2, 8'd0, 8'd0, 16'd1000},
    '{ROW_SMP, 3'd2, 49'd512, PREDICT, 8'd0, 8'd0, 16'd0},
    '{ROW_CFG, adcdb_pkg::CFG_MAP3, {1'b0, 8'd7, 8'd5, 16'd9, 16'd2}, 0,
      8'd0, 8'd0, 16'd0},
    '{ROW_SMP, 3'd3, 49'd77, 1, 8'd0, 8'd0, 16'd0},
    '{ROW_CFG, adcdb_pkg::CFG_MAP4, {1'b1, 8'd2, 8'd1, 16'h0000, 16'hFFFF}, 0,
      8'd0, 8'd0, 16'd0},
    '{ROW_SMP, 3'd4, 49'd1023, 2, 8'd1, 8'd2, 16'd0},
    '{ROW_SMP, 3'd4, 49'd300, PREDICT, 8'd0, 8'd0, 16'd0},
    '{ROW_CFG, adcdb_pkg::CFG_MAP5, {1'b1, 8'd20, 8'd10, 16'h1234, 16'h1234}, 0,
      8'd0, 8'd0, 16'd0},
    '{ROW_SMP, 3'd5, 49'd999, 2, 8'd10, 8'd20, 16'h1234},
    '{ROW_CFG, adcdb_pkg::CFG_ENABLE, 49'b010101, 0, 8'd0, 8'd0, 16'd0},
    '{ROW_SMP, 3'd1, 49'd900, 0, 8'd0, 8'd0, 16'd0},
    '{ROW_SMP, 3'd0, 49'd600, PREDICT, 8'd0, 8'd0, 16'd0},
    '{ROW_SMP, 3'd2, 49'd511, PREDICT, 8'd0, 8'd0, 16'd0}
  };

  adc_channel_deadband_scaler_unit uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  // out_a + sample*(out_b-out_a)/full scale, quotient truncated toward zero
  function automatic logic [15:0] scaled_value(input logic [9:0] smp,
                                               input adcdb_pkg::map_word_t w);
    longint lo, hi, q;
    lo = longint'(w.out_a);
    hi = longint'(w.out_b);
    q  = (longint'(smp) * (hi - lo)) / FULL_SCALE;
    return 16'(lo + q);
  endfunction

  function automatic int deadband_step(input logic [2:0] ch, input logic [9:0] smp,
                                       output adc_result_t raw, output adc_result_t wr);
    logic [9:0]           diff;
    adcdb_pkg::map_word_t w;
    raw = '0;
    wr  = '0;
    if (ch >= NUM_CH || !enable_mask[ch]) return 0;
    diff = (smp > last_reported[ch]) ? smp - last_reported[ch] : last_reported[ch] - smp;
    if (smp == last_reported[ch] || (deadband != 0 && diff < deadband)) return 0;
    last_reported[ch] = smp;
    w   = chan_map[ch];
    raw = '{adcdb_pkg::KIND_RAW, ch, 8'd0, 8'd0, 16'(smp), 1'b1};
    if (!w.mapped || w.var_id >= VAR_LIMIT) return 1;
    raw.last = 1'b0;
    wr = '{adcdb_pkg::KIND_WRITE, ch, w.var_id, w.var_idx, scaled_value(smp, w), 1'b1};
    return 2;
  endfunction

  function automatic string show_result(input adc_result_t r);
    return $sformatf("kind=%0d chan=%0d var=%0d index=%0d value=0x%04h last=%0d",
                     r.kind, r.chan, r.tgt_var, r.tgt_idx, r.value, r.last);
  endfunction

  // stop offering, let every expected result drain, then let in-flight dropped samples clear
  task automatic quiesce();
    s_tvalid  <= 1'b0;
    cfg_valid <= 1'b0;
    while (reports_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // leaves cfg_valid high so back-to-back writes need no extra step
  task automatic write_reg(input adcdb_pkg::cfg_reg_t idx,
                           input logic [adcdb_pkg::MAP_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      adcdb_pkg::CFG_ENABLE: enable_mask = val[5:0];
      adcdb_pkg::CFG_THRESH: deadband = val[9:0];
      default:               chan_map[int'(idx) - int'(adcdb_pkg::CFG_MAP0)] = val;
    endcase
  endtask

  task automatic feed_sample(input logic [2:0] ch, input logic [9:0] smp, input int n_typed,
                             input adc_result_t typed_wr);
    adc_result_t raw, wr;
    int          n, gap;
    gap = burst_mode ? 0 : $urandom_range(0, 16);
    cfg_valid <= 1'b0;
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {3'b000, smp, ch};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    n = deadband_step(ch, smp, raw, wr);
    if (n_typed != PREDICT) begin
      n   = n_typed;
      raw = '{adcdb_pkg::KIND_RAW, ch, 8'd0, 8'd0, 16'(smp), 1'(n == 1)};
      wr  = typed_wr;
    end
    if (n > 0) reports_due.push_back(raw);
    if (n > 1) reports_due.push_back(wr);
  endtask

  always @(posedge clk) begin
    adc_result_t got;
    if (!rst && m_tvalid && m_tready) begin
      got = '{adcdb_pkg::kind_t'(m_tuser), m_tdata[2:0], m_tdata[10:3], m_tdata[18:11],
              m_tdata[34:19], m_tlast};
      if (reports_due.size() == 0) begin
        $display("%0t: unexpected result: got %s", $time, show_result(got));
        errors++;
      end else begin
        if (got !== reports_due[0]) begin
          $display("%0t: result mismatch: expected %s", $time, show_result(reports_due[0]));
          $display("%0t:                   got      %s", $time, show_result(got));
          errors++;
        end
        void'(reports_due.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("tb_adc_channel_deadband_scaler_unit: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // receiver: random stall per transaction, one long hold-off on request
  initial begin
    int gap;
    while (rst) @(posedge clk);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end
      gap = burst_mode ? 0 : $urandom_range(0, 16);
      if (gap != 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
    end
  end

  initial begin
    adc_result_t          typed_wr;
    adcdb_pkg::map_word_t w;
    logic [2:0]           ch;
    logic [9:0]           smp;
    int                   pick, thr, off, near, items;
    enable_mask = '0;
    deadband    = '0;
    foreach (chan_map[c]) chan_map[c] = '0;
    foreach (last_reported[c]) last_reported[c] = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_plan[i]) begin
      if (dir_plan[i].op == ROW_CFG) begin
        quiesce();
        write_reg(adcdb_pkg::cfg_reg_t'(dir_plan[i].sel), dir_plan[i].data);
      end else begin
        typed_wr = '{adcdb_pkg::KIND_WRITE, dir_plan[i].sel, dir_plan[i].w_var,
                     dir_plan[i].w_idx, dir_plan[i].w_val, 1'b1};
        feed_sample(dir_plan[i].sel, dir_plan[i].data[9:0], dir_plan[i].n_exp, typed_wr);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      quiesce();
      burst_mode = (p == 5);
      // phase 1 runs with every channel disabled
      if (p == 1) write_reg(adcdb_pkg::CFG_ENABLE, '0);
      else if ($urandom_range(0, 1) != 0) write_reg(adcdb_pkg::CFG_ENABLE, 49'h3F);
      else write_reg(adcdb_pkg::CFG_ENABLE, adcdb_pkg::MAP_W'($urandom_range(0, 63)));
      pick = $urandom_range(0, 9);
      case (p)
        0:       thr = 1023;
        2:       thr = 1;
        default: thr = (pick < 4) ? 0 : (pick < 7) ? $urandom_range(1, 16) : $urandom_range(0, 1023);
      endcase
      write_reg(adcdb_pkg::CFG_THRESH, adcdb_pkg::MAP_W'(thr));
      for (int c = 0; c < NUM_CH; c++) begin
        w.mapped  = ($urandom_range(0, 9) != 0);
        w.var_idx = 8'($urandom);
        w.var_id  = ($urandom_range(0, 4) != 0) ? 8'($urandom_range(0, VAR_LIMIT - 1))
                                                 : 8'($urandom_range(VAR_LIMIT, 255));
        pick      = $urandom_range(0, 9);
        w.out_a   = (pick == 0) ? 16'h0000 : (pick == 1) ? 16'hFFFF : 16'($urandom);
        w.out_b   = (pick == 0) ? 16'hFFFF : (pick == 1) ? 16'h0000 : 16'($urandom);
        write_reg(adcdb_pkg::cfg_reg_t'(int'(adcdb_pkg::CFG_MAP0) + c), w);
      end
      // phase 5: no idling, receiver holds off long enough to back up the input
      if (p == 5) hold_off_req = 1'b1;
      items = (p == 1) ? 30 : 100;
      for (int k = 0; k < items; k++) begin
        if (p == 7 && k == items / 2) quiesce();
        pick = $urandom_range(0, 99);
        ch   = (pick < 5) ? 3'(6 + $urandom_range(0, 1)) : 3'($urandom_range(0, NUM_CH - 1));
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
          smp = '0;
        end else if (pick < 20) begin
          smp = 10'd1023;
        end else if (pick < 45) begin
          // land around the deadband edge of the stored value
          off = $urandom_range(0, thr + 2);
          if ($urandom_range(0, 1) != 0) off = -off;
          near = int'(last_reported[int'(ch) % NUM_CH]) + off;
          near = (near < 0) ? 0 : (near > FULL_SCALE) ? FULL_SCALE : near;
          smp  = 10'(near);
        end else begin
          smp = 10'($urandom);
        end
        feed_sample(ch, smp, PREDICT, '0);
      end
    end

    quiesce();
    if (errors == 0) begin
      $display("tb_adc_channel_deadband_scaler_unit: PASS");
    end else begin
      $display("tb_adc_channel_deadband_scaler_unit: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
